// File: rtl/configurable_crc_engine_assert.svh
// Assertion macros used by the checker file.
`ifndef CONFIGURABLE_CRC_ENGINE_ASSERT_SVH
`define CONFIGURABLE_CRC_ENGINE_ASSERT_SVH

// Same-cycle implication, off while reset is asserted
`define CRCE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crc engine check failed");

// Next-cycle implication, off while reset is asserted
`define CRCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crc engine check failed");

`endif

// File: rtl/crce_pkg.sv
package crce_pkg;

    localparam int DATA_W = 8;
    localparam int CRC_W  = 16;
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;
    localparam int APB_W  = 32;

    // Register indexes (byte address is 4 * index)
    localparam logic [IDX_W-1:0] IDX_WIDTH_MODE  = 3'd0;
    localparam logic [IDX_W-1:0] IDX_POLY        = 3'd1;
    localparam logic [IDX_W-1:0] IDX_INIT_VALUE  = 3'd2;
    localparam logic [IDX_W-1:0] IDX_XOR_OUT     = 3'd3;
    localparam logic [IDX_W-1:0] IDX_REFLECT_IN  = 3'd4;
    localparam logic [IDX_W-1:0] IDX_REFLECT_OUT = 3'd5;

    // Reset values of the configuration
    localparam logic             WIDTH_MODE_RST = 1'b1;
    localparam logic [CRC_W-1:0] POLY_RST       = 16'h1021;
    localparam logic [CRC_W-1:0] INIT_RST       = 16'h0000;
    localparam logic [CRC_W-1:0] XOR_OUT_RST    = 16'h0000;

    typedef struct packed {
        logic             width_mode;
        logic [CRC_W-1:0] poly;
        logic [CRC_W-1:0] init_value;
        logic [CRC_W-1:0] xor_out;
        logic             reflect_in;
        logic             reflect_out;
    } crce_cfg_t;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    function automatic logic [15:0] rev16(input logic [15:0] v);
        logic [15:0] r;
        for (int i = 0; i < 16; i++) begin
            r[i] = v[15-i];
        end
        return r;
    endfunction

    // Fold one byte into the CRC, MSB first; eight shift steps unrolled to XOR logic
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b,
                                             input logic        wide,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = wide ? (crc_in ^ {b, 8'h00}) : {8'h00, crc_in[7:0] ^ b};
        for (int i = 0; i < 8; i++) begin
            if (wide) begin
                c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
            end
            else begin
                c[7:0] = c[7] ? ({c[6:0], 1'b0} ^ poly[7:0]) : {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/crce_if.sv
// Message byte channel
interface crce_in_if;
    logic                        valid;
    logic                        ready;
    logic [crce_pkg::DATA_W-1:0] data_byte;
    logic                        last_byte;

    modport source(output valid, data_byte, last_byte, input ready);
    modport sink(input valid, data_byte, last_byte, output ready);
endinterface

// Checksum result channel
interface crce_out_if;
    logic                       valid;
    logic                       ready;
    logic [crce_pkg::CRC_W-1:0] crc_value;

    modport source(output valid, crc_value, input ready);
    modport sink(input valid, crc_value, output ready);
endinterface

// File: rtl/crce_regs.sv
module crce_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [crce_pkg::ADDR_W-1:0]   paddr,
    input  logic [crce_pkg::APB_W-1:0]    pwdata,
    output logic [crce_pkg::APB_W-1:0]    prdata,
    output logic                          pready,
    output crce_pkg::crce_cfg_t           cfg
);

    logic                         width_mode_reg;
    logic [crce_pkg::CRC_W-1:0]   poly_reg;
    logic [crce_pkg::CRC_W-1:0]   init_value_reg;
    logic [crce_pkg::CRC_W-1:0]   xor_out_reg;
    logic                         reflect_in_reg;
    logic                         reflect_out_reg;
    logic                         wr_en;
    logic [crce_pkg::IDX_W-1:0]   idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[crce_pkg::ADDR_W-1:2];

    // Write the addressed register; drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_mode_reg  <= crce_pkg::WIDTH_MODE_RST;
            poly_reg        <= crce_pkg::POLY_RST;
            init_value_reg  <= crce_pkg::INIT_RST;
            xor_out_reg     <= crce_pkg::XOR_OUT_RST;
            reflect_in_reg  <= 1'b0;
            reflect_out_reg <= 1'b0;
        end
        else if (wr_en) begin
            unique case (idx)
                crce_pkg::IDX_WIDTH_MODE:  width_mode_reg  <= pwdata[0];
                crce_pkg::IDX_POLY:        poly_reg        <= pwdata[crce_pkg::CRC_W-1:0];
                crce_pkg::IDX_INIT_VALUE:  init_value_reg  <= pwdata[crce_pkg::CRC_W-1:0];
                crce_pkg::IDX_XOR_OUT:     xor_out_reg     <= pwdata[crce_pkg::CRC_W-1:0];
                crce_pkg::IDX_REFLECT_IN:  reflect_in_reg  <= pwdata[0];
                crce_pkg::IDX_REFLECT_OUT: reflect_out_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        prdata = '0;
        unique case (idx)
            crce_pkg::IDX_WIDTH_MODE:  prdata[0] = width_mode_reg;
            crce_pkg::IDX_POLY:        prdata[crce_pkg::CRC_W-1:0] = poly_reg;
            crce_pkg::IDX_INIT_VALUE:  prdata[crce_pkg::CRC_W-1:0] = init_value_reg;
            crce_pkg::IDX_XOR_OUT:     prdata[crce_pkg::CRC_W-1:0] = xor_out_reg;
            crce_pkg::IDX_REFLECT_IN:  prdata[0] = reflect_in_reg;
            crce_pkg::IDX_REFLECT_OUT: prdata[0] = reflect_out_reg;
            default:                   prdata = '0;
        endcase
    end

    assign cfg.width_mode  = width_mode_reg;
    assign cfg.poly        = poly_reg;
    assign cfg.init_value  = init_value_reg;
    assign cfg.xor_out     = xor_out_reg;
    assign cfg.reflect_in  = reflect_in_reg;
    assign cfg.reflect_out = reflect_out_reg;

endmodule

// File: rtl/crce_core.sv
module crce_core (
    input  logic                clk,
    input  logic                rst_n,
    input  crce_pkg::crce_cfg_t cfg,
    crce_in_if.sink             msg,
    crce_out_if.source          crc
);

    logic                          s1_valid_reg;
    logic [crce_pkg::DATA_W-1:0]   s1_data_reg;
    logic                          s1_last_reg;
    logic [crce_pkg::CRC_W-1:0]    crc_reg;
    logic                          in_msg_reg;
    logic                          out_valid_reg;
    logic [crce_pkg::CRC_W-1:0]    out_crc_reg;

    logic                          fire;
    logic [crce_pkg::CRC_W-1:0]    base;
    logic [crce_pkg::DATA_W-1:0]   byte_in;
    logic [crce_pkg::CRC_W-1:0]    folded;
    logic [crce_pkg::CRC_W-1:0]    crc_next;
    logic [crce_pkg::CRC_W-1:0]    refl;
    logic [crce_pkg::CRC_W-1:0]    result_next;

    // Advance the input stage unless a last byte waits on a full result register
    assign fire      = s1_valid_reg && (!s1_last_reg || !out_valid_reg || crc.ready);
    assign msg.ready = !s1_valid_reg || fire;

    // Load init at message start, fold the byte, finish on the last byte
    always_comb begin
        base     = in_msg_reg ? crc_reg : cfg.init_value;
        byte_in  = cfg.reflect_in ? crce_pkg::rev8(s1_data_reg) : s1_data_reg;
        folded   = crce_pkg::crc_byte(base, byte_in, cfg.width_mode, cfg.poly);
        crc_next = cfg.width_mode ? folded : {base[15:8], folded[7:0]};
        if (cfg.reflect_out) begin
            refl = cfg.width_mode ? crce_pkg::rev16(folded)
                                  : {8'h00, crce_pkg::rev8(folded[7:0])};
        end
        else begin
            refl = cfg.width_mode ? folded : {8'h00, folded[7:0]};
        end
        result_next = cfg.width_mode ? (refl ^ cfg.xor_out)
                                     : {8'h00, refl[7:0] ^ cfg.xor_out[7:0]};
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            in_msg_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= '0;
        end
        else begin
            if (msg.ready) begin
                s1_valid_reg <= msg.valid;
            end
            if (fire) begin
                crc_reg    <= crc_next;
                in_msg_reg <= !s1_last_reg;
            end
            if (fire && s1_last_reg) begin
                out_valid_reg <= 1'b1;
            end
            else if (crc.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: hold the input byte and the finished checksum
    always_ff @(posedge clk) begin
        if (msg.valid && msg.ready) begin
            s1_data_reg <= msg.data_byte;
            s1_last_reg <= msg.last_byte;
        end
        if (fire && s1_last_reg) begin
            out_crc_reg <= result_next;
        end
    end

    assign crc.valid     = out_valid_reg;
    assign crc.crc_value = out_crc_reg;

endmodule

// File: rtl/configurable_crc_engine.sv
// The last byte is held in the input stage, then its checksum in the result register.
// Throughput: one byte per cycle unless the input stalls; the CRC update of a byte
// is XOR logic between the input stage and the CRC register.
// Input stalls only while a finished checksum waits and the next byte is also last.
// Reset (rst_n low, asynchronous) restores register defaults and starts a new message.
module configurable_crc_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [crce_pkg::ADDR_W-1:0] paddr,
    input  logic [crce_pkg::APB_W-1:0]  pwdata,
    output logic [crce_pkg::APB_W-1:0]  prdata,
    output logic                        pready,
    crce_in_if.sink                     msg,
    crce_out_if.source                  crc
);

    crce_pkg::crce_cfg_t cfg;

    crce_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crce_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .msg   (msg),
        .crc   (crc)
    );

endmodule

// File: rtl/crce_checker.sv
`include "configurable_crc_engine_assert.svh"

module crce_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       pready,
    input logic                       msg_valid,
    input logic                       msg_ready,
    input logic                       msg_last,
    input logic                       crc_valid,
    input logic                       crc_ready,
    input logic [crce_pkg::CRC_W-1:0] crc_value
);

    // Config port never waits
    `CRCE_ASSERT_NOW(a_pready_high, clk, rst_n, 1'b1, pready)

    // Stalled result holds its value
    `CRCE_ASSERT_NEXT(a_out_hold, clk, rst_n, crc_valid && !crc_ready,
        crc_valid && $stable(crc_value))

    // A new result follows an earlier last-byte transaction
    `CRCE_ASSERT_NOW(a_out_cause, clk, rst_n, $rose(crc_valid),
        $past(msg_valid && msg_ready && msg_last, 2))

    // Input is open whenever no result is pending
    `CRCE_ASSERT_NOW(a_ready_when_idle, clk, rst_n, !crc_valid, msg_ready)

endmodule

bind configurable_crc_engine crce_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .msg_valid (msg.valid),
    .msg_ready (msg.ready),
    .msg_last  (msg.last_byte),
    .crc_valid (crc.valid),
    .crc_ready (crc.ready),
    .crc_value (crc.crc_value)
);
